FILE: design/imucf_pkg.sv
// ----------------------------------------------------------------------------
// imucf_pkg: shared definitions for the IMU complementary attitude filter
// Register indexes and widths, default parameter values, reset values of the
// configuration registers and the sequencer state type.
// ----------------------------------------------------------------------------
package imucf_pkg;

	// Default values of the top level parameters.
	localparam int FRAC_BITS_DEF      = 4;
	localparam int GAIN_FRAC_BITS_DEF = 16;
	localparam int SAMPLE_WIDTH_DEF   = 16;

	// Fixed widths of the state and the configuration registers.
	localparam int ACC_W       = 32;
	localparam int GAIN_W      = 16;
	localparam int ADIV_W      = 16;
	localparam int BDIV_W      = 24;
	localparam int CFG_DATA_W  = 24;
	localparam int CFG_INDEX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_RATE_GAIN     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_DIVISOR = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BIAS_DIVISOR  = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [GAIN_W-1:0] RATE_GAIN_RST     = 16'd1507;
	localparam logic [ADIV_W-1:0] ANGLE_DIVISOR_RST = 16'd128;
	localparam logic [BDIV_W-1:0] BIAS_DIVISOR_RST  = 24'd1000000;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CORR,
		ST_MUL,
		ST_ANG,
		ST_ERR,
		ST_LOAD,
		ST_DIV,
		ST_UPD,
		ST_CONV,
		ST_DONE
	} state_t;

endpackage

FILE: design/imu_complementary_attitude_filter_unit.sv
// ----------------------------------------------------------------------------
// imu_complementary_attitude_filter_unit: roll and pitch complementary filter
// Tracks angle and gyro bias per axis in fixed point and corrects both from the
// accelerometer angle through a shared bit-serial divider.
// ----------------------------------------------------------------------------
// The input stalls from accept until the result is loaded into the output
// register, so no new item is taken before the current one is through.
// The divider retires one quotient bit per cycle, once per axis, on an error
// of max(32, SAMPLE_WIDTH+FRAC_BITS)+1 bits.
// Reset clears the angle and bias estimates, loads the register defaults and
// leaves the block idle and ready; no output item is pending after reset.
module imu_complementary_attitude_filter_unit #(
	parameter int FRAC_BITS      = imucf_pkg::FRAC_BITS_DEF,
	parameter int GAIN_FRAC_BITS = imucf_pkg::GAIN_FRAC_BITS_DEF,
	parameter int SAMPLE_WIDTH   = imucf_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Configuration write port.
	input  logic                                   cfg_we,
	input  logic [imucf_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [imucf_pkg::CFG_DATA_W-1:0]       cfg_data,
	// Input channel.
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]         roll_rate_raw,
	input  logic signed [SAMPLE_WIDTH-1:0]         roll_angle_meas,
	input  logic signed [SAMPLE_WIDTH-1:0]         pitch_rate_raw,
	input  logic signed [SAMPLE_WIDTH-1:0]         pitch_angle_meas,
	// Output channel.
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]         roll_angle_est,
	output logic signed [SAMPLE_WIDTH-1:0]         roll_rate_est,
	output logic signed [SAMPLE_WIDTH-1:0]         pitch_angle_est,
	output logic signed [SAMPLE_WIDTH-1:0]         pitch_rate_est
);

	// The corrected rate and the angle error both need one bit more than the
	// wider of the 32-bit state and the scaled sample. The product with the
	// unsigned gain grows by the gain width plus a sign bit.
	localparam int ACC_W  = imucf_pkg::ACC_W;
	localparam int ADIV_W = imucf_pkg::ADIV_W;
	localparam int BDIV_W = imucf_pkg::BDIV_W;
	localparam int GAIN_W = imucf_pkg::GAIN_W;
	localparam int FX_W   = SAMPLE_WIDTH + FRAC_BITS;
	localparam int WIDE_W = ((FX_W > ACC_W) ? FX_W : ACC_W) + 1;
	localparam int PROD_W = WIDE_W + GAIN_W + 1;
	localparam int CNT_W  = $clog2(WIDE_W);
	localparam int HALF   = (FRAC_BITS > 0) ? (1 << (FRAC_BITS - 1)) : 0;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDE_W - 1);
	localparam logic [WIDE_W:0] OUT_HI  = (WIDE_W + 1)'((1 << (SAMPLE_WIDTH - 1)) - 1);
	localparam logic [WIDE_W:0] OUT_NEG = (WIDE_W + 1)'(1 << (SAMPLE_WIDTH - 1));

	// Configuration registers.
	logic [GAIN_W-1:0] rate_gain_q;
	logic [ADIV_W-1:0] angle_div_q;
	logic [BDIV_W-1:0] bias_div_q;

	// Filter state, one entry per axis: index 0 is roll, index 1 is pitch.
	logic signed [ACC_W-1:0] angle_acc_q [2];
	logic signed [ACC_W-1:0] bias_acc_q  [2];

	// Captured input item.
	logic signed [SAMPLE_WIDTH-1:0] rate_q [2];
	logic signed [SAMPLE_WIDTH-1:0] meas_q [2];

	// Sequencer.
	imucf_pkg::state_t state_q, state_d;
	logic              axis_q;
	logic [CNT_W-1:0]  cnt_q;

	// Working registers of the current axis.
	logic signed [WIDE_W-1:0] corr_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  ang_tmp_q;
	logic signed [WIDE_W-1:0] err_q;
	logic                     neg_q;

	// Shared divider: one dividend shifted out a bit per cycle, two remainders
	// and quotients, one for the angle divisor and one for the bias divisor.
	logic [WIDE_W-1:0] dvd_q;
	logic [ADIV_W-1:0] ra_q;
	logic [BDIV_W-1:0] rb_q;
	logic [WIDE_W-1:0] qa_q;
	logic [WIDE_W-1:0] qb_q;

	// Per-axis results waiting for the output register.
	logic signed [SAMPLE_WIDTH-1:0] res_angle_q [2];
	logic signed [SAMPLE_WIDTH-1:0] res_rate_q  [2];

	// Output register.
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] out_roll_angle_q;
	logic signed [SAMPLE_WIDTH-1:0] out_roll_rate_q;
	logic signed [SAMPLE_WIDTH-1:0] out_pitch_angle_q;
	logic signed [SAMPLE_WIDTH-1:0] out_pitch_rate_q;

	// Decoded controls.
	logic in_accept_c;
	logic out_load_c;

	// Datapath signals.
	logic [ADIV_W-1:0]        adiv_eff;
	logic [BDIV_W-1:0]        bdiv_eff;
	logic signed [WIDE_W-1:0] rate_fx;
	logic signed [WIDE_W-1:0] meas_fx;
	logic signed [WIDE_W-1:0] bias_wide;
	logic signed [PROD_W-1:0] prod_shr;
	logic signed [GAIN_W:0]   gain_s;
	logic [ADIV_W:0]          ra_sh;
	logic [BDIV_W:0]          rb_sh;
	logic                     ra_ge;
	logic                     rb_ge;
	logic [ADIV_W:0]          ra_diff;
	logic [BDIV_W:0]          rb_diff;
	logic [ACC_W-1:0]         qa_s;
	logic [ACC_W-1:0]         qb_s;

	// Rounds a fixed-point value half away from zero to an integer and
	// saturates it to the signed sample range.
	function automatic logic signed [SAMPLE_WIDTH-1:0] rnd_sat(
		input logic signed [WIDE_W-1:0] v
	);
		logic             neg;
		logic [WIDE_W:0]  mag;
		logic [WIDE_W:0]  rnd;
		logic [SAMPLE_WIDTH-1:0] res;
		neg = v[WIDE_W-1];
		mag = neg ? ((WIDE_W + 1)'(0) - {v[WIDE_W-1], v}) : {1'b0, v};
		rnd = (mag + (WIDE_W + 1)'(HALF)) >> FRAC_BITS;
		if (!neg && (rnd > OUT_HI)) begin
			res = OUT_HI[SAMPLE_WIDTH-1:0];
		end else if (neg && (rnd > OUT_NEG)) begin
			res = OUT_NEG[SAMPLE_WIDTH-1:0];
		end else if (neg) begin
			res = SAMPLE_WIDTH'(0) - rnd[SAMPLE_WIDTH-1:0];
		end else begin
			res = rnd[SAMPLE_WIDTH-1:0];
		end
		return signed'(res);
	endfunction

	// A divisor register that holds zero divides by one.
	assign adiv_eff = (angle_div_q == '0) ? ADIV_W'(1) : angle_div_q;
	assign bdiv_eff = (bias_div_q == '0) ? BDIV_W'(1) : bias_div_q;

	// Fixed-point views of the current axis.
	assign rate_fx   = WIDE_W'(rate_q[axis_q]) <<< FRAC_BITS;
	assign meas_fx   = WIDE_W'(meas_q[axis_q]) <<< FRAC_BITS;
	assign bias_wide = WIDE_W'(bias_acc_q[axis_q]);
	assign gain_s    = signed'({1'b0, rate_gain_q});

	// The arithmetic shift floors the product; the state keeps its low word.
	assign prod_shr = prod_q >>> GAIN_FRAC_BITS;

	// One restoring step for each divisor on the shared dividend bit.
	assign ra_sh   = {ra_q, dvd_q[WIDE_W-1]};
	assign rb_sh   = {rb_q, dvd_q[WIDE_W-1]};
	assign ra_diff = ra_sh - {1'b0, adiv_eff};
	assign rb_diff = rb_sh - {1'b0, bdiv_eff};
	assign ra_ge   = (ra_sh >= {1'b0, adiv_eff});
	assign rb_ge   = (rb_sh >= {1'b0, bdiv_eff});

	// Quotients carry the sign of the error; truncation toward zero follows
	// from dividing the magnitude.
	assign qa_s = neg_q ? (ACC_W'(0) - qa_q[ACC_W-1:0]) : qa_q[ACC_W-1:0];
	assign qb_s = neg_q ? (ACC_W'(0) - qb_q[ACC_W-1:0]) : qb_q[ACC_W-1:0];

	// Configuration writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_gain_q <= imucf_pkg::RATE_GAIN_RST;
			angle_div_q <= imucf_pkg::ANGLE_DIVISOR_RST;
			bias_div_q  <= imucf_pkg::BIAS_DIVISOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				imucf_pkg::REG_RATE_GAIN:     rate_gain_q <= cfg_data[GAIN_W-1:0];
				imucf_pkg::REG_ANGLE_DIVISOR: angle_div_q <= cfg_data[ADIV_W-1:0];
				imucf_pkg::REG_BIAS_DIVISOR:  bias_div_q  <= cfg_data[BDIV_W-1:0];
				default: ;
			endcase
		end
	end

	// Next state. Each axis runs the corrected rate, the gain product, the
	// angle prediction, the error, the divider load, one divider step per
	// quotient bit, the state update and the output rounding.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			imucf_pkg::ST_IDLE: begin
				if (in_valid) state_d = imucf_pkg::ST_CORR;
			end
			imucf_pkg::ST_CORR: state_d = imucf_pkg::ST_MUL;
			imucf_pkg::ST_MUL:  state_d = imucf_pkg::ST_ANG;
			imucf_pkg::ST_ANG:  state_d = imucf_pkg::ST_ERR;
			imucf_pkg::ST_ERR:  state_d = imucf_pkg::ST_LOAD;
			imucf_pkg::ST_LOAD: state_d = imucf_pkg::ST_DIV;
			imucf_pkg::ST_DIV: begin
				if (cnt_q == '0) state_d = imucf_pkg::ST_UPD;
			end
			imucf_pkg::ST_UPD:  state_d = imucf_pkg::ST_CONV;
			imucf_pkg::ST_CONV: begin
				state_d = axis_q ? imucf_pkg::ST_DONE : imucf_pkg::ST_CORR;
			end
			imucf_pkg::ST_DONE: begin
				if (out_load_c) state_d = imucf_pkg::ST_IDLE;
			end
			default: state_d = imucf_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs. The block takes a new item while an earlier result
	// still waits in the output register; it only holds the last result of
	// the new item until that register is free.
	always_comb begin
		in_stall    = (state_q != imucf_pkg::ST_IDLE);
		in_accept_c = (state_q == imucf_pkg::ST_IDLE) && in_valid;
		out_load_c  = (state_q == imucf_pkg::ST_DONE) && (!out_valid_q || !out_stall);
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= imucf_pkg::ST_IDLE;
			axis_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_accept_c) begin
				axis_q <= 1'b0;
			end else if ((state_q == imucf_pkg::ST_CONV) && !axis_q) begin
				axis_q <= 1'b1;
			end
			if (state_q == imucf_pkg::ST_LOAD) begin
				cnt_q <= CNT_LAST;
			end else if (state_q == imucf_pkg::ST_DIV) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (out_load_c) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Filter state: cleared by reset, written once per axis and item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_acc_q[0] <= '0;
			angle_acc_q[1] <= '0;
			bias_acc_q[0]  <= '0;
			bias_acc_q[1]  <= '0;
		end else if (state_q == imucf_pkg::ST_UPD) begin
			angle_acc_q[axis_q] <= ang_tmp_q - signed'(qa_s);
			bias_acc_q[axis_q]  <= bias_acc_q[axis_q] + signed'(qb_s);
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_accept_c) begin
			rate_q[0] <= roll_rate_raw;
			meas_q[0] <= roll_angle_meas;
			rate_q[1] <= pitch_rate_raw;
			meas_q[1] <= pitch_angle_meas;
		end
		unique case (state_q)
			imucf_pkg::ST_CORR: corr_q <= rate_fx - bias_wide;
			imucf_pkg::ST_MUL:  prod_q <= PROD_W'(corr_q) * PROD_W'(gain_s);
			imucf_pkg::ST_ANG:  ang_tmp_q <= angle_acc_q[axis_q] + prod_shr[ACC_W-1:0];
			imucf_pkg::ST_ERR:  err_q <= WIDE_W'(ang_tmp_q) - meas_fx;
			imucf_pkg::ST_LOAD: begin
				neg_q <= err_q[WIDE_W-1];
				dvd_q <= err_q[WIDE_W-1] ? (WIDE_W'(0) - err_q) : err_q;
				ra_q  <= '0;
				rb_q  <= '0;
				qa_q  <= '0;
				qb_q  <= '0;
			end
			imucf_pkg::ST_DIV: begin
				dvd_q <= dvd_q << 1;
				ra_q  <= ra_ge ? ra_diff[ADIV_W-1:0] : ra_sh[ADIV_W-1:0];
				rb_q  <= rb_ge ? rb_diff[BDIV_W-1:0] : rb_sh[BDIV_W-1:0];
				qa_q  <= {qa_q[WIDE_W-2:0], ra_ge};
				qb_q  <= {qb_q[WIDE_W-2:0], rb_ge};
			end
			imucf_pkg::ST_CONV: begin
				res_angle_q[axis_q] <= rnd_sat(WIDE_W'(angle_acc_q[axis_q]));
				res_rate_q[axis_q]  <= rnd_sat(corr_q);
			end
			default: ;
		endcase
		if (out_load_c) begin
			out_roll_angle_q  <= res_angle_q[0];
			out_roll_rate_q   <= res_rate_q[0];
			out_pitch_angle_q <= res_angle_q[1];
			out_pitch_rate_q  <= res_rate_q[1];
		end
	end

	assign out_valid       = out_valid_q;
	assign roll_angle_est  = out_roll_angle_q;
	assign roll_rate_est   = out_roll_rate_q;
	assign pitch_angle_est = out_pitch_angle_q;
	assign pitch_rate_est  = out_pitch_rate_q;

	// The output register is loaded only when the sequencer finishes an item.
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == imucf_pkg::ST_DONE)
		else $error("output item appeared outside the final step");

	// The state update follows a complete division.
	a_div_complete: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == imucf_pkg::ST_UPD |->
			($past(state_q) == imucf_pkg::ST_DIV) && ($past(cnt_q) == '0))
		else $error("state updated before the divider finished");

	// Restoring division keeps both partial remainders below their divisors.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == imucf_pkg::ST_DIV |-> (ra_q < adiv_eff) && (rb_q < bdiv_eff))
		else $error("divider remainder out of range");

	// Both axes are done before an item completes.
	a_both_axes: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == imucf_pkg::ST_DONE |-> axis_q)
		else $error("item finished before the pitch axis");

endmodule
